// ===== rtl/core/matrix_inverse_3x3_top_defines.svh =====
// Assertion macros shared by the matrix inverse RTL.
`ifndef MATRIX_INVERSE_3X3_TOP_DEFINES_SVH
`define MATRIX_INVERSE_3X3_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define MI3_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define MI3_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) ante |=> cons) else $error(msg);
`else
`define MI3_ASSERT(lbl, prop, msg)
`define MI3_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/mi3_pkg.sv =====
// Types, widths, stage numbers and cofactor tables of the 3x3 matrix inverse.
package mi3_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ELEM_W    = 32;
    localparam int THR_W     = 17;
    localparam int N_ELEM    = 9;
    localparam int N_DET     = 3;

    localparam int PROD_W = 2 * ELEM_W;
    localparam int COF_W  = PROD_W + 1;
    localparam int CABS_W = PROD_W;
    localparam int LO_W   = 2 * ELEM_W + 1;
    localparam int HI_W   = COF_W;
    localparam int TERM_W = ELEM_W + COF_W;
    localparam int DET_W  = TERM_W + 2;
    localparam int SNUM_W = CABS_W + 2 * FRAC_BITS;
    localparam int NUM_W  = ((SNUM_W > DET_W) ? SNUM_W : DET_W) + 1;
    localparam int QB     = ELEM_W + 1;

    // Pipeline stage numbers, counted from the stage that takes the item.
    localparam int ST_IN    = 0;
    localparam int ST_COF   = 1;
    localparam int ST_PP    = 2;
    localparam int ST_TERM  = 3;
    localparam int ST_SUM   = 4;
    localparam int ST_ABS   = 5;
    localparam int ST_SETUP = 6;
    localparam int ST_OVF   = 7;
    localparam int ST_OUT   = ST_OVF + QB + 1;
    localparam int NST      = ST_OUT + 1;

    // Cofactor k is m[A]*m[B] - m[C]*m[D], elements numbered column-major.
    localparam logic [3:0] CF_A [N_ELEM] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
    localparam logic [3:0] CF_B [N_ELEM] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
    localparam logic [3:0] CF_C [N_ELEM] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
    localparam logic [3:0] CF_D [N_ELEM] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

    // Lanes whose cofactors expand the determinant down the first column.
    localparam logic [3:0] DET_LANE [N_DET] = '{4'd0, 4'd3, 4'd6};

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef logic signed [COF_W-1:0]  t_cof;

    typedef struct packed {
        t_elem col0_row0;
        t_elem col0_row1;
        t_elem col0_row2;
        t_elem col1_row0;
        t_elem col1_row1;
        t_elem col1_row2;
        t_elem col2_row0;
        t_elem col2_row1;
        t_elem col2_row2;
    } t_in_item;

    typedef struct packed {
        t_elem inv_c0_r0;
        t_elem inv_c0_r1;
        t_elem inv_c0_r2;
        t_elem inv_c1_r0;
        t_elem inv_c1_r1;
        t_elem inv_c1_r2;
        t_elem inv_c2_r0;
        t_elem inv_c2_r1;
        t_elem inv_c2_r2;
        logic  singular;
    } t_out_item;

    typedef struct packed {
        logic [DET_W-1:0] dabs;
        logic             dneg;
        logic             sing;
    } t_det_res;

endpackage

// ===== rtl/core/mi3_if.sv =====
// Handshake channel interfaces for the matrix inverse: input, result and configuration.
interface mi3_in_if import mi3_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mi3_out_if import mi3_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mi3_cfg_if import mi3_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [THR_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/mi3_cof_lane.sv =====
// One cofactor lane: two products, their difference, and its magnitude and sign.
module mi3_cof_lane import mi3_pkg::*; (
    input  logic              i_clk,
    input  logic [NST-1:0]    i_en,
    input  t_elem             i_a,
    input  t_elem             i_b,
    input  t_elem             i_c,
    input  t_elem             i_d,
    output t_cof              o_cof,
    output logic [CABS_W-1:0] o_cabs,
    output logic              o_cneg
);

    logic signed [PROD_W-1:0] r_pa;
    logic signed [PROD_W-1:0] r_pb;
    t_cof                     r_cof;
    t_cof                     w_ncof;
    logic [CABS_W-1:0]        r_cabs [ST_ABS-ST_PP+1];
    logic                     r_cneg [ST_ABS-ST_PP+1];

    assign w_ncof = -r_cof;

    always_ff @(posedge i_clk) begin
        if (i_en[ST_IN]) begin
            r_pa <= i_a * i_b;
            r_pb <= i_c * i_d;
        end
        if (i_en[ST_COF]) begin
            r_cof <= {r_pa[PROD_W-1], r_pa} - {r_pb[PROD_W-1], r_pb};
        end
        if (i_en[ST_PP]) begin
            r_cabs[0] <= r_cof[COF_W-1] ? w_ncof[CABS_W-1:0] : r_cof[CABS_W-1:0];
            r_cneg[0] <= r_cof[COF_W-1];
        end
        for (int k = 1; k <= ST_ABS - ST_PP; k++) begin
            if (i_en[ST_PP+k]) begin
                r_cabs[k] <= r_cabs[k-1];
                r_cneg[k] <= r_cneg[k-1];
            end
        end
    end

    assign o_cof  = r_cof;
    assign o_cabs = r_cabs[ST_ABS-ST_PP];
    assign o_cneg = r_cneg[ST_ABS-ST_PP];

endmodule

// ===== rtl/core/mi3_det.sv =====
// Merging stage: expands the determinant from three lanes and tests it against the threshold.
module mi3_det import mi3_pkg::*; (
    input  logic             i_clk,
    input  logic [NST-1:0]   i_en,
    input  t_elem            i_m [N_DET],
    input  t_cof             i_cof [N_DET],
    input  logic [THR_W-1:0] i_thr,
    output t_det_res         o_det
);

    t_elem                    r_m0 [N_DET];
    t_elem                    r_m1 [N_DET];
    logic signed [LO_W-1:0]   r_lo [N_DET];
    logic signed [HI_W-1:0]   r_hi [N_DET];
    logic signed [TERM_W-1:0] r_term [N_DET];
    logic signed [DET_W-1:0]  r_det;
    logic signed [DET_W-1:0]  w_thr;
    logic signed [DET_W-1:0]  w_ndet;
    t_det_res                 r_res;

    // The threshold is in element scale; the determinant carries two more fraction fields.
    assign w_thr  = DET_W'({i_thr, {(2 * FRAC_BITS){1'b0}}});
    assign w_ndet = -r_det;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < N_DET; i++) begin
            if (i_en[ST_IN]) begin
                r_m0[i] <= i_m[i];
            end
            if (i_en[ST_COF]) begin
                r_m1[i] <= r_m0[i];
            end
            if (i_en[ST_PP]) begin
                r_lo[i] <= r_m1[i] * $signed({1'b0, i_cof[i][ELEM_W-1:0]});
                r_hi[i] <= r_m1[i] * $signed(i_cof[i][COF_W-1:ELEM_W]);
            end
            if (i_en[ST_TERM]) begin
                r_term[i] <= (TERM_W'(r_hi[i]) <<< ELEM_W) + TERM_W'(r_lo[i]);
            end
        end
        if (i_en[ST_SUM]) begin
            r_det <= DET_W'(r_term[0]) + DET_W'(r_term[1]) + DET_W'(r_term[2]);
        end
        if (i_en[ST_ABS]) begin
            r_res.dabs <= r_det[DET_W-1] ? w_ndet : r_det;
            r_res.dneg <= r_det[DET_W-1];
            r_res.sing <= (r_det <= w_thr) && (r_det >= -w_thr);
        end
    end

    assign o_det = r_res;

endmodule

// ===== rtl/core/mi3_div_lane.sv =====
// One division lane: rounded quotient of a cofactor by the determinant, one bit a stage.
module mi3_div_lane import mi3_pkg::*; (
    input  logic              i_clk,
    input  logic [NST-1:0]    i_en,
    input  logic [CABS_W-1:0] i_cabs,
    input  logic              i_cneg,
    input  t_det_res          i_det,
    input  logic              i_sing,
    output t_elem             o_res
);

    localparam logic [QB-1:0] POS_LIM = QB'(1) << (ELEM_W - 1);

    logic [NUM_W-1:0] r_num0;
    logic [DET_W-1:0] r_d0;
    logic             r_ng0;
    logic [NUM_W-1:0] r_rem [QB];
    logic [DET_W-1:0] r_dv  [QB];
    logic [QB-1:0]    r_q   [QB+1];
    logic             r_ng  [QB+1];
    logic             r_ov  [QB+1];
    logic [QB:1]      w_ge;
    logic [QB-1:0]    w_q;
    logic [ELEM_W-1:0] w_negq;
    t_elem            w_val;
    t_elem            r_res;

    always_ff @(posedge i_clk) begin
        if (i_en[ST_SETUP]) begin
            // Adding half the divisor rounds to nearest, ties away from zero.
            r_num0 <= NUM_W'({i_cabs, {(2 * FRAC_BITS){1'b0}}}) + NUM_W'(i_det.dabs >> 1);
            r_d0   <= i_det.dabs;
            r_ng0  <= i_cneg ^ i_det.dneg;
        end
        if (i_en[ST_OVF]) begin
            r_rem[0] <= r_num0;
            r_dv[0]  <= r_d0;
            r_q[0]   <= '0;
            r_ng[0]  <= r_ng0;
            r_ov[0]  <= (r_num0 >> QB) >= NUM_W'(r_d0);
        end
    end

    for (genvar s = 1; s <= QB; s++) begin : g_step
        localparam int J = QB - s;

        assign w_ge[s] = (r_rem[s-1] >> J) >= NUM_W'(r_dv[s-1]);

        always_ff @(posedge i_clk) begin
            if (i_en[ST_OVF+s]) begin
                r_q[s]  <= {r_q[s-1][QB-2:0], w_ge[s]};
                r_ng[s] <= r_ng[s-1];
                r_ov[s] <= r_ov[s-1];
            end
        end

        if (s < QB) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en[ST_OVF+s]) begin
                    r_rem[s] <= w_ge[s] ? r_rem[s-1] - (NUM_W'(r_dv[s-1]) << J) : r_rem[s-1];
                    r_dv[s]  <= r_dv[s-1];
                end
            end
        end
    end

    assign w_q    = r_q[QB];
    assign w_negq = -w_q[ELEM_W-1:0];

    always_comb begin
        if (r_ng[QB]) begin
            w_val = (r_ov[QB] || (w_q > POS_LIM)) ? {1'b1, {(ELEM_W-1){1'b0}}} : w_negq;
        end else begin
            w_val = (r_ov[QB] || (w_q >= POS_LIM)) ? {1'b0, {(ELEM_W-1){1'b1}}}
                                                   : w_q[ELEM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[ST_OUT]) begin
            r_res <= i_sing ? '0 : w_val;
        end
    end

    assign o_res = r_res;

endmodule

// ===== rtl/core/matrix_inverse_3x3_top.sv =====
// Top level of the 3x3 matrix inverse by the adjugate, nine lanes wide.
//
//  Channel   Direction  Handshake          Carries
//  i_in      in         valid / ready      one matrix, nine Q16.16 elements, column-major
//  o_out     out        valid / ready      the inverse, nine Q16.16 elements, and singular
//  i_cfg     in         valid / ready      det_threshold, Q1.16 magnitude, 17 bits
//
// An item taken at the input passes through six stages of products and determinant, a
// division set-up and an overflow stage, 33 stages that each settle one quotient bit of a
// saturated Q16.16 result, and the output.
// Reset is synchronous and active low; it empties the pipeline and clears det_threshold.
// Each stage moves forward whenever some stage at or after it is empty, so bubbles close up;
// the input is held off only when all 42 stages hold items and the result is not taken.
`include "matrix_inverse_3x3_top_defines.svh"

module matrix_inverse_3x3_top import mi3_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    mi3_in_if.sink     i_in,
    mi3_out_if.source  o_out,
    mi3_cfg_if.sink    i_cfg
);

    logic [THR_W-1:0]  r_thr;
    logic [NST-1:0]    r_v;
    logic [NST-1:0]    w_ld;
    t_elem             w_m [N_ELEM];
    t_cof              w_cof [N_ELEM];
    logic [CABS_W-1:0] w_cabs [N_ELEM];
    logic              w_cneg [N_ELEM];
    t_elem             w_res [N_ELEM];
    t_elem             w_dm [N_DET];
    t_cof              w_dcof [N_DET];
    t_det_res          w_det;
    logic              r_sing [ST_SETUP:ST_OUT];
    logic              w_all_zero;

    // Always ready; the user must send writes only while idle; the block does not check.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (i_cfg.valid) begin
            r_thr <= i_cfg.data;
        end
    end

    // A stage may load when it or any stage after it is empty, or the output is being taken.
    for (genvar k = 0; k < NST; k++) begin : g_load
        assign w_ld[k] = o_out.ready || !(&r_v[NST-1:k]);
    end

    assign i_in.ready = w_ld[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_ld[0]) begin
                r_v[0] <= i_in.valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_ld[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_comb begin
        w_m[0] = i_in.data.col0_row0;
        w_m[1] = i_in.data.col0_row1;
        w_m[2] = i_in.data.col0_row2;
        w_m[3] = i_in.data.col1_row0;
        w_m[4] = i_in.data.col1_row1;
        w_m[5] = i_in.data.col1_row2;
        w_m[6] = i_in.data.col2_row0;
        w_m[7] = i_in.data.col2_row1;
        w_m[8] = i_in.data.col2_row2;
    end

    // Nine cofactor lanes, one for each entry of the adjugate.
    for (genvar k = 0; k < N_ELEM; k++) begin : g_cof
        mi3_cof_lane u_cof (
            .i_clk  (i_clk),
            .i_en   (w_ld),
            .i_a    (w_m[CF_A[k]]),
            .i_b    (w_m[CF_B[k]]),
            .i_c    (w_m[CF_C[k]]),
            .i_d    (w_m[CF_D[k]]),
            .o_cof  (w_cof[k]),
            .o_cabs (w_cabs[k]),
            .o_cneg (w_cneg[k])
        );
    end

    // The determinant expands down the first column of the matrix.
    for (genvar i = 0; i < N_DET; i++) begin : g_dsel
        assign w_dm[i]   = w_m[i];
        assign w_dcof[i] = w_cof[DET_LANE[i]];
    end

    mi3_det u_det (
        .i_clk (i_clk),
        .i_en  (w_ld),
        .i_m   (w_dm),
        .i_cof (w_dcof),
        .i_thr (r_thr),
        .o_det (w_det)
    );

    // The singular flag follows its item down the division stages.
    always_ff @(posedge i_clk) begin
        if (w_ld[ST_SETUP]) begin
            r_sing[ST_SETUP] <= w_det.sing;
        end
        for (int k = ST_SETUP + 1; k <= ST_OUT; k++) begin
            if (w_ld[k]) begin
                r_sing[k] <= r_sing[k-1];
            end
        end
    end

    for (genvar k = 0; k < N_ELEM; k++) begin : g_div
        mi3_div_lane u_div (
            .i_clk  (i_clk),
            .i_en   (w_ld),
            .i_cabs (w_cabs[k]),
            .i_cneg (w_cneg[k]),
            .i_det  (w_det),
            .i_sing (r_sing[ST_OUT-1]),
            .o_res  (w_res[k])
        );
    end

    assign o_out.valid = r_v[ST_OUT];

    always_comb begin
        o_out.data.inv_c0_r0 = w_res[0];
        o_out.data.inv_c0_r1 = w_res[1];
        o_out.data.inv_c0_r2 = w_res[2];
        o_out.data.inv_c1_r0 = w_res[3];
        o_out.data.inv_c1_r1 = w_res[4];
        o_out.data.inv_c1_r2 = w_res[5];
        o_out.data.inv_c2_r0 = w_res[6];
        o_out.data.inv_c2_r1 = w_res[7];
        o_out.data.inv_c2_r2 = w_res[8];
        o_out.data.singular  = r_sing[ST_OUT];
        w_all_zero = 1'b1;
        for (int k = 0; k < N_ELEM; k++) begin
            w_all_zero = w_all_zero && (w_res[k] == '0);
        end
    end

    // A singular result carries the zero matrix.
    `MI3_ASSERT(a_sing_zero, o_out.valid && o_out.data.singular |-> w_all_zero, "singular result is not zero")
    // Input is held off only when every stage holds an item.
    `MI3_ASSERT(a_ready_full, !i_in.ready |-> (&r_v), "input stalled with a bubble in the pipeline")
    // A threshold write lands in the register on the next cycle.
    `MI3_ASSERT_NXT(a_thr_write, i_cfg.valid && i_cfg.ready, r_thr == $past(i_cfg.data), "threshold write lost")

endmodule

// ===== bench/tb_matrix_inverse_3x3_top.sv =====
// Self-checking testbench for the 3x3 matrix inverse: random and directed matrices, checked
// against an exact adjugate predictor.
`timescale 1ns / 100ps

import mi3_pkg::*;

// Works out the expected rounded inverse for every accepted matrix and checks the results in order.
class inverse_scoreboard;
    t_out_item        inverse_q[$];
    logic [THR_W-1:0] threshold;
    int               errors;
    int               n_checked;
    int               n_singular;

    function new();
        threshold  = '0;
        errors     = 0;
        n_checked  = 0;
        n_singular = 0;
    endfunction

    function logic [ELEM_W-1:0] scaled_entry(logic signed [127:0] cof,
                                              logic signed [127:0] det);
        logic        neg;
        logic [127:0] mag_det;
        logic [127:0] mag_cof;
        logic [127:0] quot;
        logic [127:0] lim;
        neg     = (cof < 0) != (det < 0);
        mag_det = (det < 0) ? -det : det;
        mag_cof = (cof < 0) ? -cof : cof;
        // Round to nearest, ties away from zero, on the magnitude.
        quot    = ((mag_cof << (2 * FRAC_BITS)) + (mag_det >> 1)) / mag_det;
        lim     = 128'd1 << (ELEM_W - 1);
        if (neg) begin
            if (quot > lim) quot = lim;
            quot = -quot;
        end else if (quot >= lim) begin
            quot = lim - 1;
        end
        return quot[ELEM_W-1:0];
    endfunction

    function void note_input(t_in_item mat);
        logic signed [127:0] m [9];
        logic signed [127:0] c [9];
        logic signed [127:0] det;
        logic [127:0]        mag_det;
        logic [289-1:0]      flat;
        t_out_item           res;
        logic [9*ELEM_W-1:0] in_flat;
        in_flat = mat;
        for (int k = 0; k < 9; k++) begin
            m[k] = $signed(in_flat[9*ELEM_W-1-ELEM_W*k -: ELEM_W]);
        end
        c[0] = m[4] * m[8] - m[5] * m[7];
        c[3] = m[5] * m[6] - m[3] * m[8];
        c[6] = m[3] * m[7] - m[4] * m[6];
        c[1] = m[2] * m[7] - m[1] * m[8];
        c[4] = m[0] * m[8] - m[2] * m[6];
        c[7] = m[1] * m[6] - m[0] * m[7];
        c[2] = m[1] * m[5] - m[2] * m[4];
        c[5] = m[2] * m[3] - m[0] * m[5];
        c[8] = m[0] * m[4] - m[1] * m[3];
        det     = m[0] * c[0] + m[1] * c[3] + m[2] * c[6];
        mag_det = (det < 0) ? -det : det;
        flat    = '0;
        if (mag_det <= (128'(threshold) << (2 * FRAC_BITS))) begin
            flat[0] = 1'b1;
        end else begin
            for (int k = 0; k < 9; k++) begin
                flat[289-1-ELEM_W*k -: ELEM_W] = scaled_entry(c[k], det);
            end
        end
        res = flat;
        inverse_q.push_back(res);
    endfunction

    function void check_result(t_out_item got);
        string          names [9] = '{"inv_c0_r0", "inv_c0_r1", "inv_c0_r2",
                                      "inv_c1_r0", "inv_c1_r1", "inv_c1_r2",
                                      "inv_c2_r0", "inv_c2_r1", "inv_c2_r2"};
        t_out_item      want;
        logic [289-1:0] fw;
        logic [289-1:0] fg;
        if (inverse_q.size() == 0) begin
            $error("result item arrived with no matrix outstanding");
            errors++;
            return;
        end
        want = inverse_q.pop_front();
        fw   = want;
        fg   = got;
        n_checked++;
        if (want.singular) n_singular++;
        for (int k = 0; k < 9; k++) begin
            if (fw[289-1-ELEM_W*k -: ELEM_W] !== fg[289-1-ELEM_W*k -: ELEM_W]) begin
                $error("%s: expected %0d, got %0d", names[k],
                       $signed(fw[289-1-ELEM_W*k -: ELEM_W]),
                       $signed(fg[289-1-ELEM_W*k -: ELEM_W]));
                errors++;
            end
        end
        if (want.singular !== got.singular) begin
            $error("singular: expected %0b, got %0b", want.singular, got.singular);
            errors++;
        end
    endfunction
endclass

module tb_matrix_inverse_3x3_top;
    localparam int  CYCLE_LIMIT = 200000;
    localparam logic signed [ELEM_W-1:0] ONE = 32'sd65536;
    localparam logic signed [ELEM_W-1:0] MAXV = 32'h7FFF_FFFF;
    localparam logic signed [ELEM_W-1:0] MINV = 32'h8000_0000;

    logic i_clk;
    logic i_rst_n;

    mi3_in_if  in_ch ();
    mi3_out_if out_ch ();
    mi3_cfg_if cfg_ch ();

    matrix_inverse_3x3_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    inverse_scoreboard sb = new();

    // When set, neither side inserts idle cycles, so the pipeline runs back to back.
    logic no_idle;
    int   n_sent;
    int   cycles;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Watchdog: the run must finish well inside the limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_matrix_inverse_3x3_top: errors");
            $finish;
        end
    end

    // Result side. Results are checked at the edge where they are taken, then ready is
    // chosen for the next cycle. Once, a long hold-off lets the pipeline fill right up so
    // that the block has to stall its input while the sender keeps offering items.
    int  hold_left;
    bit  hold_done;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
            if (!hold_done && n_sent >= 380) begin
                hold_done    <= 1'b1;
                hold_left    <= 300;
                out_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left    <= hold_left - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= no_idle || ($urandom_range(99) >= 30);
            end
        end
    end

    task automatic send_matrix(t_in_item mat);
        while (!no_idle && $urandom_range(99) < 30) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= mat;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_input(mat);
        n_sent++;
    endtask

    // The threshold is only changed once every outstanding result has come back.
    task automatic write_threshold(logic [THR_W-1:0] thr);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.inverse_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= thr;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        sb.threshold = thr;
    endtask

    function automatic t_in_item diag(t_elem a, t_elem b, t_elem c);
        return {a, 32'sd0, 32'sd0, 32'sd0, b, 32'sd0, 32'sd0, 32'sd0, c};
    endfunction

    function automatic t_elem rand_elem(int kind);
        case (kind)
            0: return t_elem'($signed(32'($urandom_range(262144))) - 131072);
            1: return t_elem'($signed(32'($urandom_range(33554432))) - 16777216);
            default: return t_elem'($urandom());
        endcase
    endfunction

    // Mostly small and moderate elements, so that determinants land on both sides of the
    // threshold and the inverse stays in range; a share of full-range elements exercises
    // every bit and the saturation logic.
    function automatic t_in_item rand_matrix();
        int                  kind;
        logic [9*ELEM_W-1:0] flat;
        int                  pick;
        pick = $urandom_range(99);
        kind = (pick < 45) ? 0 : (pick < 80) ? 1 : 2;
        for (int k = 0; k < 9; k++) flat[ELEM_W*k +: ELEM_W] = rand_elem(kind);
        // Now and then copy one column onto another to force an exactly singular matrix.
        if ($urandom_range(99) < 8) flat[ELEM_W*0 +: ELEM_W*3] = flat[ELEM_W*3 +: ELEM_W*3];
        return flat;
    endfunction

    task automatic random_phase(int n_items, int burst_from, int burst_to);
        for (int i = 0; i < n_items; i++) begin
            no_idle = (i >= burst_from) && (i < burst_to);
            send_matrix(rand_matrix());
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n      = 1'b0;
        no_idle      = 1'b0;
        n_sent       = 0;
        cycles       = 0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        out_ch.ready = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with a zero threshold: identity, zero and rank-deficient matrices,
        // the element extremes, results that saturate both ways, and rounding of thirds.
        write_threshold('0);
        send_matrix(diag(ONE, ONE, ONE));
        send_matrix('0);
        send_matrix({9{MAXV}});
        send_matrix({9{MINV}});
        send_matrix(diag(MAXV, MAXV, MAXV));
        send_matrix(diag(MINV, MINV, MAXV));
        send_matrix(diag(32'sd1, 32'sd1, 32'sd1));
        send_matrix(diag(-32'sd1, 32'sd1, 32'sd1));
        send_matrix(diag(32'sd3 * ONE, -32'sd3 * ONE, 32'sd7 * ONE));
        send_matrix({32'sd0, ONE, 32'sd0, 32'sd0, 32'sd0, ONE, ONE, 32'sd0, 32'sd0});
        send_matrix({32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                     32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA,
                     32'h1234_5678, 32'hFEDC_BA98, 32'h0F0F_0F0F});
        send_matrix({ONE, 32'sd2 * ONE, ONE, ONE, 32'sd2 * ONE, ONE,
                     32'sd5 * ONE, ONE, -ONE});
        send_matrix({ONE, 32'sd2 * ONE, 32'sd3 * ONE, 32'sd4 * ONE, 32'sd5 * ONE,
                     32'sd6 * ONE, 32'sd7 * ONE, 32'sd8 * ONE, 32'sd10 * ONE});
        random_phase(200, 60, 140);

        // A threshold of one: a determinant of exactly one is singular, one step above is not.
        write_threshold(17'd65536);
        send_matrix(diag(ONE, ONE, ONE));
        send_matrix(diag(ONE, ONE, ONE + 32'sd1));
        send_matrix(diag(ONE, -ONE, ONE));
        send_matrix(diag(ONE, -ONE, ONE + 32'sd1));
        send_matrix(diag(32'sd2 * ONE, 32'sd2 * ONE, 32'sd2 * ONE));
        random_phase(170, 100, 170);

        // A small threshold, then a random one.
        write_threshold(17'd1);
        send_matrix(diag(ONE, ONE, 32'sd1));
        send_matrix(diag(ONE, ONE, 32'sd2));
        random_phase(80, 0, 0);
        write_threshold(17'($urandom_range(65536)));
        random_phase(90, 0, 0);

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.inverse_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("Sent %0d matrices over four threshold settings; %0d results checked,",
                 n_sent, sb.n_checked);
        $display("%0d of them singular, with one long output stall.", sb.n_singular);
        if (sb.errors == 0 && sb.inverse_q.size() == 0) begin
            $display("tb_matrix_inverse_3x3_top: clean");
        end else begin
            $display("tb_matrix_inverse_3x3_top: errors");
        end
        $finish;
    end
endmodule
